### rtl/pstle_pkg.sv
// Package for the PostScript text line escaper.
// Holds character codes, the item descriptor and state types, and the
// closing sequence table. No dependencies.
package pstle_pkg;

	localparam int CNT_W     = 4;
	localparam int TAB_STOP  = 8;
	localparam int CLOSE_LEN = 5;

	localparam logic [7:0] C_NUL    = 8'h00;
	localparam logic [7:0] C_TAB    = 8'h09;
	localparam logic [7:0] C_NL     = 8'h0A;
	localparam logic [7:0] C_FF     = 8'h0C;
	localparam logic [7:0] C_SPACE  = 8'h20;
	localparam logic [7:0] C_LPAREN = 8'h28;
	localparam logic [7:0] C_RPAREN = 8'h29;
	localparam logic [7:0] C_L      = 8'h4C;
	localparam logic [7:0] C_S      = 8'h53;
	localparam logic [7:0] C_BSLASH = 8'h5C;
	localparam logic [7:0] C_DEL    = 8'h7F;
	localparam logic [7:0] C_BULLET = 8'hB7;

	typedef struct packed {
		logic [2:0] col;
		logic       skip;
		logic       trunc;
	} line_state_t;

	// what one item emits: optional '(' then n_chars bytes then optional close
	typedef struct packed {
		logic             open;
		logic [CNT_W-1:0] n_chars;
		logic             tab;
		logic             esc;
		logic [7:0]       ch;
		logic             close;
		logic [CNT_W-1:0] total;
	} item_desc_t;

	function automatic logic [7:0] close_byte(input logic [2:0] i);
		logic [7:0] b;
		case (i)
			3'd0:    b = C_RPAREN;
			3'd1:    b = C_SPACE;
			3'd2:    b = C_L;
			3'd3:    b = C_S;
			3'd4:    b = C_NL;
			default: b = C_NL;
		endcase
		return b;
	endfunction

endpackage

### rtl/pstle_if.sv
// Stream interfaces for the escaper: text characters in, PostScript bytes out.
// Valid/ready handshake; a request moves when both are high. No dependencies.
interface pstle_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] line_char;
	logic       has_char;
	logic       first_of_line;
	logic       last_of_line;

	modport source (output valid, line_char, has_char, first_of_line, last_of_line,
		input ready);
	modport sink (input valid, line_char, has_char, first_of_line, last_of_line,
		output ready);
endinterface

interface pstle_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_last;

	modport source (output valid, out_byte, run_last, input ready);
	modport sink (input valid, out_byte, run_last, output ready);
endinterface

### rtl/postscript_text_line_escaper.sv
// Top level of the PostScript text line escaper.
// Depends on pstle_pkg, pstle_if and pstle_classify.
//
// Usage:
//   text : one character of a line per request, with has_char and
//          first/last-of-line marks.
//   ps   : the PostScript show text, one byte per request; run_last marks the
//          final byte caused by one text request.
//   A text request is classified and held in stage 1, then its bytes are
//   serialised into the output register, one per cycle while ps is not
//   stalled. The first byte of a request passes through stage 1 and then the
//   output register before the ps handshake.
//   Stage 1 holds a request until its last byte has moved on; its byte count
//   is 0 to 14: '(' + up to 8 tab spaces + ") LS\n". Requests
//   giving at most one byte flow at one per cycle while ps is not stalled.
//   Stage 1 takes the next request in the cycle its last byte goes out.
//   A stalled ps side holds the output register; stage 1 then waits and text
//   ready drops once stage 1 holds unsent bytes.
//   Reset clears the line state (column, skip, truncation) and empties both
//   registers.
module postscript_text_line_escaper (
	input  logic          clk,
	input  logic          arst_n,
	pstle_in_if.sink      text,
	pstle_out_if.source   ps
);
	import pstle_pkg::*;

	line_state_t state_q;
	line_state_t state_nxt;
	item_desc_t  desc_in;

	logic             valid_s1;
	item_desc_t       desc_s1;
	logic [CNT_W-1:0] idx_s1;

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       run_last_q;

	logic             accept;
	logic             load_out;
	logic             s1_last;
	logic             s1_done;
	logic [CNT_W-1:0] pos;
	logic [CNT_W-1:0] close_pos;
	logic [7:0]       cur_byte;

	pstle_classify u_classify (
		.line_char     (text.line_char),
		.has_char      (text.has_char),
		.first_of_line (text.first_of_line),
		.last_of_line  (text.last_of_line),
		.cur           (state_q),
		.desc          (desc_in),
		.nxt           (state_nxt)
	);

	assign load_out   = valid_s1 && (desc_s1.total != '0) && (!out_valid_q || ps.ready);
	assign s1_last    = idx_s1 == (desc_s1.total - CNT_W'(1));
	assign s1_done    = valid_s1 && ((desc_s1.total == '0) || (load_out && s1_last));
	assign text.ready = !valid_s1 || s1_done;
	assign accept     = text.valid && text.ready;

	assign pos       = idx_s1 - {{(CNT_W-1){1'b0}}, desc_s1.open};
	assign close_pos = pos - desc_s1.n_chars;

	always_comb begin
		if (desc_s1.open && (idx_s1 == '0)) begin
			cur_byte = C_LPAREN;
		end else if (pos < desc_s1.n_chars) begin
			if (desc_s1.tab) begin
				cur_byte = C_SPACE;
			end else if (desc_s1.esc && (pos == '0)) begin
				cur_byte = C_BSLASH;
			end else begin
				cur_byte = desc_s1.ch;
			end
		end else begin
			cur_byte = close_byte(close_pos[2:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			valid_s1    <= 1'b0;
			idx_s1      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				state_q  <= state_nxt;
				valid_s1 <= 1'b1;
				idx_s1   <= '0;
			end else begin
				if (s1_done) begin
					valid_s1 <= 1'b0;
				end
				if (load_out) begin
					idx_s1 <= idx_s1 + CNT_W'(1);
				end
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (ps.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			desc_s1 <= desc_in;
		end
		if (load_out) begin
			out_byte_q <= cur_byte;
			run_last_q <= s1_last;
		end
	end

	assign ps.valid    = out_valid_q;
	assign ps.out_byte = out_byte_q;
	assign ps.run_last = run_last_q;

endmodule

### rtl/pstle_classify.sv
// Classifies one text character against the line state: output byte counts,
// escape/tab flags and the next state. Depends on pstle_pkg.
module pstle_classify (
	input  logic [7:0]            line_char,
	input  logic                  has_char,
	input  logic                  first_of_line,
	input  logic                  last_of_line,
	input  pstle_pkg::line_state_t cur,
	output pstle_pkg::item_desc_t  desc,
	output pstle_pkg::line_state_t nxt
);
	import pstle_pkg::*;

	line_state_t st;
	logic [7:0]  mapped;
	logic [CNT_W-1:0] n_close;

	always_comb begin
		st = cur;
		if (first_of_line) begin
			st.col   = 3'd0;
			st.trunc = 1'b0;
			st.skip  = has_char && (line_char == C_FF);
		end

		mapped = ((line_char < C_SPACE) || (line_char > C_DEL)) ? C_BULLET : line_char;

		desc         = '0;
		desc.ch      = mapped;
		nxt          = st;
		if (!st.skip) begin
			desc.open  = first_of_line;
			desc.close = last_of_line;
			if (has_char && !st.trunc) begin
				if (line_char == C_NUL) begin
					nxt.trunc = 1'b1;
				end else if (line_char == C_TAB) begin
					desc.tab     = 1'b1;
					desc.n_chars = CNT_W'(TAB_STOP) - {1'b0, st.col};
					nxt.col      = 3'd0;
				end else begin
					desc.esc     = (mapped == C_LPAREN) || (mapped == C_RPAREN) ||
						(mapped == C_BSLASH);
					desc.n_chars = desc.esc ? CNT_W'(2) : CNT_W'(1);
					nxt.col      = st.col + 3'd1;
				end
			end
		end
		n_close    = desc.close ? CNT_W'(CLOSE_LEN) : '0;
		desc.total = {{(CNT_W-1){1'b0}}, desc.open} + desc.n_chars + n_close;
	end

endmodule

### rtl/pstle_checker.sv
// Port-level checks for the PostScript text line escaper, bound to the top.
// Depends on pstle_pkg and postscript_text_line_escaper.
module pstle_port_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       run_last
);
	import pstle_pkg::*;

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(run_last))
		else $error("stalled output changed");

	// newline only ever closes a line, so it is the final byte of its request
	a_nl_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_byte == C_NL) |-> run_last)
		else $error("newline not marked last");

	// control bytes never leak apart from the closing newline
	a_no_ctrl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_byte < C_SPACE) |-> out_byte == C_NL)
		else $error("control byte emitted");

	// high bytes are always replaced by the bullet
	a_no_high: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_byte > C_DEL) |-> out_byte == C_BULLET)
		else $error("unmapped high byte emitted");

endmodule

bind postscript_text_line_escaper pstle_port_checker u_pstle_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (ps.valid),
	.out_ready (ps.ready),
	.out_byte  (ps.out_byte),
	.run_last  (ps.run_last)
);

### tb/pstle_checker.sv
// Checker for the PostScript text line escaper: watches the text and ps channels,
// predicts the PostScript bytes of every accepted text request and compares them.
// Depends on pstle_pkg and pstle_if.
module pstle_checker (
	input  logic  clk,
	input  logic  arst_n,
	pstle_in_if   text,
	pstle_out_if  ps,
	output int    errors,
	output int    pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import pstle_pkg::*;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
	} ps_byte_t;

	ps_byte_t   ps_expected[$];
	logic [2:0] column;
	logic       skipping;
	logic       cut;
	int         n_err;

	function automatic void escape_text(input logic [7:0] c, input logic has,
		input logic first, input logic last);
		logic [7:0] bytes[$];
		logic [7:0] ch;
		int         spaces;
		ps_byte_t   e;
		if (first) begin
			column   = 3'd0;
			cut      = 1'b0;
			skipping = has && c == C_FF;
		end
		if (skipping)
			return;
		if (first)
			bytes.push_back(C_LPAREN);
		if (has && !cut) begin
			if (c == C_NUL) begin
				cut = 1'b1;
			end else if (c == C_TAB) begin
				spaces = TAB_STOP - int'(column);
				repeat (spaces) bytes.push_back(C_SPACE);
				column = 3'd0;
			end else begin
				ch = (c < C_SPACE || c > C_DEL) ? C_BULLET : c;
				if (ch == C_LPAREN || ch == C_RPAREN || ch == C_BSLASH)
					bytes.push_back(C_BSLASH);
				bytes.push_back(ch);
				column = column + 3'd1;
			end
		end
		if (last) begin
			bytes.push_back(C_RPAREN);
			bytes.push_back(C_SPACE);
			bytes.push_back(C_L);
			bytes.push_back(C_S);
			bytes.push_back(C_NL);
		end
		foreach (bytes[i]) begin
			e.out_byte = bytes[i];
			e.run_last = (i == bytes.size() - 1);
			ps_expected.push_back(e);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		ps_byte_t e;
		if (!arst_n) begin
			ps_expected.delete();
			column   = 3'd0;
			skipping = 1'b0;
			cut      = 1'b0;
			n_err    = 0;
			errors  <= 0;
			pending <= 0;
		end else begin
			if (text.valid && text.ready)
				escape_text(text.line_char, text.has_char, text.first_of_line,
					text.last_of_line);
			if (ps.valid && ps.ready) begin
				if (ps_expected.size() == 0) begin
					$error("unexpected ps request: out_byte %h run_last %b",
						ps.out_byte, ps.run_last);
					n_err++;
				end else begin
					e = ps_expected.pop_front();
					if (ps.out_byte !== e.out_byte) begin
						$error("out_byte: expected %h, got %h", e.out_byte, ps.out_byte);
						n_err++;
					end
					if (ps.run_last !== e.run_last) begin
						$error("run_last: expected %b, got %b", e.run_last, ps.run_last);
						n_err++;
					end
				end
			end
			errors  <= n_err;
			pending <= ps_expected.size();
		end
	end

endmodule

### tb/testbench.sv
// Top of the escaper testbench: clock, reset, text stimulus and ps backpressure.
// Instantiates postscript_text_line_escaper and pstle_checker; depends on
// pstle_pkg and pstle_if.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import pstle_pkg::*;

	localparam int ITEMS      = 460;
	localparam int QUIET_TAIL = 60;
	localparam int LONG_HOLD  = 80;
	localparam int HOLD_AT    = 300;
	localparam int IDLE_LIMIT = 2000;
	localparam int TAIL       = 20;

	logic clk;
	logic arst_n;
	logic quiet;
	int   n_sent;
	int   errors;
	int   pending;

	pstle_in_if  text_if ();
	pstle_out_if ps_if ();

	postscript_text_line_escaper i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_if),
		.ps     (ps_if)
	);

	pstle_checker i_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.text    (text_if),
		.ps      (ps_if),
		.errors  (errors),
		.pending (pending)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic offer_char(input logic [7:0] c, input logic has, input logic first,
		input logic last);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			text_if.valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		text_if.valid         <= 1'b1;
		text_if.line_char     <= c;
		text_if.has_char      <= has;
		text_if.first_of_line <= first;
		text_if.last_of_line  <= last;
		do @(posedge clk); while (!text_if.ready);
		n_sent++;
		if (n_sent == ITEMS - QUIET_TAIL)
			quiet <= 1'b1;
	endtask

	function automatic logic [7:0] pick_char();
		logic [7:0] c;
		case ($urandom_range(0, 15))
			0:       c = C_LPAREN;
			1:       c = C_RPAREN;
			2:       c = C_BSLASH;
			3, 4:    c = C_TAB;
			5:       c = ($urandom_range(0, 2) == 0) ? C_NUL : 8'($urandom_range(32, 126));
			6:       c = 8'($urandom_range(0, 31));
			7:       c = 8'($urandom_range(128, 255));
			8:       c = C_DEL;
			9:       c = 8'($urandom_range(0, 255));
			default: c = 8'($urandom_range(32, 126));
		endcase
		return c;
	endfunction

	task automatic send_line(input bit noisy);
		int         len;
		logic [7:0] c;
		logic       has;
		logic       first;
		logic       last;
		if ($urandom_range(0, 11) == 0) begin
			offer_char(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b1);
			return;
		end
		len = $urandom_range(1, 12);
		for (int i = 0; i < len; i++) begin
			c     = pick_char();
			has   = ($urandom_range(0, 19) != 0);
			first = (i == 0);
			last  = (i == len - 1);
			if (first && $urandom_range(0, 7) == 0)
				c = C_FF;
			if (noisy) begin
				has   = 1'($urandom_range(0, 1));
				first = ($urandom_range(0, 3) == 0);
				last  = ($urandom_range(0, 3) == 0);
			end
			offer_char(c, has, first, last);
		end
	endtask

	// ps side: random stall bursts, one long hold-off, none in the quiet tail
	initial begin
		int stall_left;
		int cycles;
		stall_left = 0;
		cycles     = 0;
		ps_if.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles == HOLD_AT) begin
				stall_left = LONG_HOLD - 1;
				ps_if.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				ps_if.ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 7) - 1;
				ps_if.ready <= 1'b0;
			end else begin
				ps_if.ready <= 1'b1;
			end
		end
	end

	initial begin
		int idle;
		idle = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if ((text_if.valid && text_if.ready) || (ps_if.valid && ps_if.ready))
				idle = 0;
			else
				idle++;
			if (idle >= IDLE_LIMIT) begin
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		quiet  = 1'b0;
		n_sent = 0;
		text_if.valid         <= 1'b0;
		text_if.line_char     <= 8'h00;
		text_if.has_char      <= 1'b0;
		text_if.first_of_line <= 1'b0;
		text_if.last_of_line  <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty line
		offer_char(8'h41, 1'b0, 1'b1, 1'b1);
		// escapes
		offer_char(C_LPAREN, 1'b1, 1'b1, 1'b0);
		offer_char(C_RPAREN, 1'b1, 1'b0, 1'b0);
		offer_char(C_BSLASH, 1'b1, 1'b0, 1'b1);
		// tabs from column 0 and 3, range edges
		offer_char(C_TAB, 1'b1, 1'b1, 1'b0);
		offer_char(8'h20, 1'b1, 1'b0, 1'b0);
		offer_char(8'h7E, 1'b1, 1'b0, 1'b0);
		offer_char(C_DEL, 1'b1, 1'b0, 1'b0);
		offer_char(C_TAB, 1'b1, 1'b0, 1'b0);
		offer_char(8'h1F, 1'b1, 1'b0, 1'b0);
		offer_char(8'h80, 1'b1, 1'b0, 1'b0);
		offer_char(8'hFF, 1'b1, 1'b0, 1'b1);
		// form-feed line, swallowed whole
		offer_char(C_FF, 1'b1, 1'b1, 1'b0);
		offer_char(8'h78, 1'b1, 1'b0, 1'b1);
		// NUL truncates, close still emitted
		offer_char(8'h61, 1'b1, 1'b1, 1'b0);
		offer_char(C_NUL, 1'b1, 1'b0, 1'b0);
		offer_char(C_TAB, 1'b1, 1'b0, 1'b0);
		offer_char(8'h63, 1'b1, 1'b0, 1'b1);
		// items outside a line
		offer_char(8'h7A, 1'b1, 1'b0, 1'b0);
		offer_char(8'h71, 1'b1, 1'b0, 1'b1);
		// first without a byte, mid-line form feed, last without a byte
		offer_char(8'h00, 1'b0, 1'b1, 1'b0);
		offer_char(C_FF, 1'b1, 1'b0, 1'b0);
		offer_char(8'hAA, 1'b0, 1'b0, 1'b1);
		// longest burst: open, full tab, close
		offer_char(C_TAB, 1'b1, 1'b1, 1'b1);

		while (n_sent < ITEMS)
			send_line($urandom_range(0, 9) == 0);
		text_if.valid <= 1'b0;

		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (TAIL) @(posedge clk);
		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

### sim.f
rtl/pstle_pkg.sv
rtl/pstle_if.sv
rtl/pstle_classify.sv
rtl/postscript_text_line_escaper.sv
rtl/pstle_checker.sv
tb/pstle_checker.sv
tb/testbench.sv
